### src/brs_pkg.sv
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: shared package
// Types and constants used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package brs_pkg;

   // Register field widths.
   localparam int SizeW   = 13;
   localparam int OrientW = 2;
   localparam int AddrW   = 26;
   localparam int WordW   = 16;
   localparam int StrideW = SizeW + 2;

   // Job queue between the front and back ends.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam int QueueCntW  = 3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_ROWS      = 2'd1,
      CSR_ORIENT_MODE     = 2'd2,
      CSR_SOURCE_TOP_DOWN = 2'd3
   } csr_index_type;

   // Orientation modes (any other code keeps the source order).
   localparam logic [OrientW-1:0] ORIENT_TOP_DOWN  = 2'd1;
   localparam logic [OrientW-1:0] ORIENT_BOTTOM_UP = 2'd2;

   // Byte phase of the front end.
   typedef enum logic [1:0] {
      PH_BLUE  = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

   // Clamped configuration seen by both ends.
   typedef struct packed {
      logic [SizeW-1:0] width;
      logic [SizeW-1:0] rows;
      logic             flip;
      logic             odd;
   } cfg_type;

   // One pixel job handed from the front end to the back end.
   typedef struct packed {
      logic [WordW-1:0] pixel;
      logic [SizeW-1:0] column;
      logic [SizeW-1:0] dest_row;
      logic             pad;
      logic             image_end;
   } job_type;

endpackage

### src/brs_front.sv
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: front end
// Collects blue, green and red bytes, drops source row padding, keeps the
// column and row counters and issues one pixel job per completed triple.
// ----------------------------------------------------------------------------
module brs_front (
   input  logic              clock,
   input  logic              reset,
   input  brs_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic [7:0]        source_byte,
   output logic              job_push,
   output brs_pkg::job_type  job
);

   brs_pkg::phase_type             phase_ff, phase_in;
   logic [7:0]                     blue_ff, blue_in;
   logic [7:0]                     green_ff, green_in;
   logic [brs_pkg::SizeW-1:0]      column_ff, column_in;
   logic [brs_pkg::SizeW-1:0]      row_ff, row_in;
   logic [1:0]                     skip_ff, skip_in;

   logic [brs_pkg::SizeW-1:0]      col_clamp;
   logic [brs_pkg::SizeW-1:0]      row_clamp;
   logic [brs_pkg::SizeW:0]        column_next;
   logic [brs_pkg::SizeW:0]        row_next;
   logic                           row_end;
   logic                           image_end;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= brs_pkg::PH_BLUE;
         blue_ff   <= '0;
         green_ff  <= '0;
         column_ff <= '0;
         row_ff    <= '0;
         skip_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         skip_ff   <= skip_in;
      end
   end

   // Position of the pixel that the red byte completes.
   always_comb begin
      column_next = {1'b0, column_ff} + 1'b1;
      row_next    = {1'b0, row_ff} + 1'b1;
      row_end     = column_next >= {1'b0, cfg.width};
      image_end   = row_end && (row_next >= {1'b0, cfg.rows});
      col_clamp   = (column_ff < cfg.width) ? column_ff : cfg.width - 1'b1;
      row_clamp   = (row_ff < cfg.rows) ? row_ff : cfg.rows - 1'b1;
   end

   // Job contents.
   always_comb begin
      job.pixel     = {source_byte[7:3], green_ff[7:2], blue_ff[7:3]};
      job.column    = col_clamp;
      job.dest_row  = cfg.flip ? (cfg.rows - 1'b1 - row_clamp) : row_clamp;
      job.pad       = row_end && cfg.odd;
      job.image_end = image_end;
   end

   // Next state of the byte sequencer.
   always_comb begin
      phase_in  = phase_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      column_in = column_ff;
      row_in    = row_ff;
      skip_in   = skip_ff;
      job_push  = 1'b0;
      if (accept) begin
         case (phase_ff)
            brs_pkg::PH_BLUE: begin
               blue_in  = source_byte;
               phase_in = brs_pkg::PH_GREEN;
            end
            brs_pkg::PH_GREEN: begin
               green_in = source_byte;
               phase_in = brs_pkg::PH_RED;
            end
            brs_pkg::PH_RED: begin
               job_push = 1'b1;
               if (row_end) begin
                  column_in = '0;
                  row_in    = image_end ? '0 : row_next[brs_pkg::SizeW-1:0];
                  skip_in   = cfg.width[1:0];
                  phase_in  = (cfg.width[1:0] != 2'd0) ? brs_pkg::PH_SKIP
                                                       : brs_pkg::PH_BLUE;
               end else begin
                  column_in = column_next[brs_pkg::SizeW-1:0];
                  phase_in  = brs_pkg::PH_BLUE;
               end
            end
            brs_pkg::PH_SKIP: begin
               if (skip_ff <= 2'd1) begin
                  skip_in  = '0;
                  phase_in = brs_pkg::PH_BLUE;
               end else begin
                  skip_in = skip_ff - 2'd1;
               end
            end
            default: begin
               phase_in = brs_pkg::PH_BLUE;
            end
         endcase
      end
   end

endmodule

### src/brs_queue.sv
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: job queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module brs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brs_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output brs_pkg::job_type  head_job
);

   brs_pkg::job_type                 entry_ff [brs_pkg::QueueDepth];
   logic [brs_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [brs_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [brs_pkg::QueueCntW-1:0]    count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   // Status and head entry.
   always_comb begin
      full       = count_ff == brs_pkg::QueueCntW'(brs_pkg::QueueDepth);
      head_valid = count_ff != '0;
      head_job   = entry_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/brs_back.sv
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: back end
// Forms the destination address of each job (row multiply, then add) and
// delivers the pixel word and, at the end of an odd row, the pad word.
// ----------------------------------------------------------------------------
module brs_back #(
   parameter int HEADER_BYTES = 66
) (
   input  logic                        clock,
   input  logic                        reset,
   input  brs_pkg::cfg_type            cfg,
   input  logic                        job_valid,
   input  brs_pkg::job_type            job,
   output logic                        job_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [brs_pkg::WordW-1:0]   rsp_output_word,
   output logic [brs_pkg::AddrW-1:0]   rsp_write_address,
   output logic                        rsp_is_pad,
   output logic                        rsp_run_last,
   output logic                        rsp_image_done
);

   localparam logic [brs_pkg::AddrW-1:0] HeaderAddr = brs_pkg::AddrW'(HEADER_BYTES);

   // Multiply stage.
   logic                              s1_valid_ff, s1_valid_in;
   brs_pkg::job_type                  s1_job_ff;
   logic [brs_pkg::AddrW-1:0]         s1_prod_ff;
   logic [brs_pkg::StrideW-1:0]       stride;
   logic [brs_pkg::StrideW+brs_pkg::SizeW-1:0] prod;
   logic                              s1_take;

   // Output stage.
   logic                              out_valid_ff, out_valid_in;
   logic [brs_pkg::WordW-1:0]         out_word_ff, out_word_in;
   logic [brs_pkg::AddrW-1:0]         out_addr_ff, out_addr_in;
   logic                              out_pad_ff, out_pad_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_done_ff, out_done_in;
   logic                              pend_ff, pend_in;
   logic                              pend_done_ff, pend_done_in;
   logic                              out_free;

   // Row stride is twice the width rounded up to a multiple of four.
   always_comb begin
      stride = {1'b0, cfg.width, 1'b0} + (cfg.odd ? brs_pkg::StrideW'(2)
                                                  : brs_pkg::StrideW'(0));
      prod   = stride * job.dest_row;
   end

   // Stage handshakes: the pad word blocks the next pixel until it is loaded.
   always_comb begin
      out_free    = !out_valid_ff || !rsp_stall;
      s1_take     = out_free && !pend_ff && s1_valid_ff;
      job_pop     = job_valid && (!s1_valid_ff || s1_take);
      s1_valid_in = job_pop ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);
   end

   // Multiply stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_job_ff  <= job;
         s1_prod_ff <= prod[brs_pkg::AddrW-1:0];
      end
   end

   // Output register selection: pending pad word first, then the next pixel.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_addr_in  = out_addr_ff;
      out_pad_in   = out_pad_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      pend_in      = pend_ff;
      pend_done_in = pend_done_ff;
      if (out_free) begin
         if (pend_ff) begin
            out_valid_in = 1'b1;
            out_word_in  = '0;
            out_addr_in  = out_addr_ff + brs_pkg::AddrW'(2);
            out_pad_in   = 1'b1;
            out_last_in  = 1'b1;
            out_done_in  = pend_done_ff;
            pend_in      = 1'b0;
         end else if (s1_valid_ff) begin
            out_valid_in = 1'b1;
            out_word_in  = s1_job_ff.pixel;
            out_addr_in  = HeaderAddr + s1_prod_ff
                         + {{(brs_pkg::AddrW-brs_pkg::SizeW-1){1'b0}},
                            s1_job_ff.column, 1'b0};
            out_pad_in   = 1'b0;
            out_last_in  = !s1_job_ff.pad;
            out_done_in  = s1_job_ff.image_end && !s1_job_ff.pad;
            pend_in      = s1_job_ff.pad;
            pend_done_in = s1_job_ff.image_end;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      out_addr_ff  <= out_addr_in;
      out_pad_ff   <= out_pad_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
      pend_done_ff <= pend_done_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_output_word   = out_word_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_is_pad        = out_pad_ff;
   assign rsp_run_last      = out_last_ff;
   assign rsp_image_done    = out_done_ff;

endmodule

### src/bgr888_to_rgb565_row_stream.sv
// A pixel word passes through the job queue, the multiply stage and the output register.
// Throughput: one source byte per cycle while the job queue is not full and req_stall is low.
// The back end delivers one result per cycle unless rsp_stall holds it; a padded pixel gives two results.
// A four-entry job queue absorbs output stalls before req_stall rises.
// Synchronous reset returns the registers to their defaults and empties all stages.
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: top level
// Configuration registers, clamping, and the front end, queue and back end.
// ----------------------------------------------------------------------------
module bgr888_to_rgb565_row_stream #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_ROWS     = 4096,
   parameter int HEADER_BYTES = 66
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_source_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [brs_pkg::WordW-1:0]   rsp_output_word,
   output logic [brs_pkg::AddrW-1:0]   rsp_write_address,
   output logic                        rsp_is_pad,
   output logic                        rsp_run_last,
   output logic                        rsp_image_done,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [brs_pkg::SizeW-1:0]   csr_data
);

   localparam logic [brs_pkg::SizeW+1:0] MaxWidth = (brs_pkg::SizeW+2)'(MAX_WIDTH);
   localparam logic [brs_pkg::SizeW+1:0] MaxRows  = (brs_pkg::SizeW+2)'(MAX_ROWS);

   logic [brs_pkg::SizeW-1:0]    width_ff;
   logic [brs_pkg::SizeW-1:0]    rows_ff;
   logic [brs_pkg::OrientW-1:0]  orient_ff;
   logic                         top_down_ff;
   brs_pkg::cfg_type             cfg;

   logic                         accept;
   logic                         job_push;
   brs_pkg::job_type             push_job;
   logic                         queue_full;
   logic                         job_pop;
   logic                         head_valid;
   brs_pkg::job_type             head_job;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= brs_pkg::SizeW'(1);
         rows_ff     <= brs_pkg::SizeW'(1);
         orient_ff   <= '0;
         top_down_ff <= 1'b0;
      end else if (csr_valid) begin
         case (brs_pkg::csr_index_type'(csr_index))
            brs_pkg::CSR_IMAGE_WIDTH:     width_ff    <= csr_data;
            brs_pkg::CSR_IMAGE_ROWS:      rows_ff     <= csr_data;
            brs_pkg::CSR_ORIENT_MODE:     orient_ff   <= csr_data[brs_pkg::OrientW-1:0];
            brs_pkg::CSR_SOURCE_TOP_DOWN: top_down_ff <= csr_data[0];
            default:                      top_down_ff <= top_down_ff;
         endcase
      end
   end

   // Clamp the sizes into range and decide on the vertical flip.
   always_comb begin
      if (width_ff == '0) begin
         cfg.width = brs_pkg::SizeW'(1);
      end else if ({2'b00, width_ff} > MaxWidth) begin
         cfg.width = MaxWidth[brs_pkg::SizeW-1:0];
      end else begin
         cfg.width = width_ff;
      end
      if (rows_ff == '0) begin
         cfg.rows = brs_pkg::SizeW'(1);
      end else if ({2'b00, rows_ff} > MaxRows) begin
         cfg.rows = MaxRows[brs_pkg::SizeW-1:0];
      end else begin
         cfg.rows = rows_ff;
      end
      cfg.flip = ((orient_ff == brs_pkg::ORIENT_TOP_DOWN) && !top_down_ff)
              || ((orient_ff == brs_pkg::ORIENT_BOTTOM_UP) && top_down_ff);
      cfg.odd  = cfg.width[0];
   end

   // Input handshake: hold off only while the job queue is full.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   brs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .source_byte (req_source_byte),
      .job_push    (job_push),
      .job         (push_job)
   );

   brs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   brs_back #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .job_valid         (head_valid),
      .job               (head_job),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_output_word   (rsp_output_word),
      .rsp_write_address (rsp_write_address),
      .rsp_is_pad        (rsp_is_pad),
      .rsp_run_last      (rsp_run_last),
      .rsp_image_done    (rsp_image_done)
   );

endmodule

### src/brs_checker.sv
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: port checker
// Watches the result channel and checks the pixel and pad word sequence.
// ----------------------------------------------------------------------------
module brs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [brs_pkg::WordW-1:0]   rsp_output_word,
   input logic [brs_pkg::AddrW-1:0]   rsp_write_address,
   input logic                        rsp_is_pad,
   input logic                        rsp_run_last,
   input logic                        rsp_image_done
);

   // A stalled result keeps its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_output_word)
         && $stable(rsp_write_address) && $stable(rsp_is_pad))
      else $error("result changed while stalled");

   // A pad word is zero and always closes its request.
   a_pad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_pad |-> rsp_output_word == '0 && rsp_run_last)
      else $error("pad word malformed");

   // The end of the image is always the last result of its request.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_run_last)
      else $error("image end on a non-final result");

   // A pixel that is not last is followed at once by its pad word, two bytes on.
   a_pad_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid && rsp_is_pad
         && rsp_write_address == $past(rsp_write_address) + brs_pkg::AddrW'(2))
      else $error("pad word missing after the last pixel of an odd row");

endmodule

bind bgr888_to_rgb565_row_stream brs_checker u_brs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_output_word   (rsp_output_word),
   .rsp_write_address (rsp_write_address),
   .rsp_is_pad        (rsp_is_pad),
   .rsp_run_last      (rsp_run_last),
   .rsp_image_done    (rsp_image_done)
);

### verif/bgr888_to_rgb565_row_stream_tb.sv
// ----------------------------------------------------------------------------
// BGR888 to RGB565 row stream: testbench
// Streams bitmap pixel bytes into the converter under random source and sink
// pauses, predicts every RGB565 word, pad word and address in a scoreboard,
// and compares each delivered word field by field in arrival order.
// ----------------------------------------------------------------------------
module bgr888_to_rgb565_row_stream_tb;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_ROWS     = 4096;
   localparam int HEADER_BYTES = 66;

   // Cycles allowed after the last expected word before touching the registers.
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 880;
   localparam int WIDE_RUN_BYTES = 3 * 40;
   localparam int CYCLE_LIMIT  = 500000;

   // One converted word as it leaves the block.
   typedef struct packed {
      logic [brs_pkg::WordW-1:0] word;
      logic [brs_pkg::AddrW-1:0] address;
      logic                      is_pad;
      logic                      run_last;
      logic                      image_done;
   } rgb565_word_type;

   // Scoreboard: a copy of the converter state plus the words still owed.
   class rgb565_scoreboard_type;
      logic [brs_pkg::SizeW-1:0]   cfg_width;
      logic [brs_pkg::SizeW-1:0]   cfg_rows;
      logic [brs_pkg::OrientW-1:0] cfg_orient;
      logic                        cfg_top_down;
      brs_pkg::phase_type          phase;
      logic [7:0]                  held_blue;
      logic [7:0]                  held_green;
      logic [brs_pkg::SizeW-1:0]   column;
      logic [brs_pkg::SizeW-1:0]   row;
      logic [1:0]                  skip;
      rgb565_word_type             pending_words[$];
      int                          mismatch_count;

      function new();
         cfg_width = brs_pkg::SizeW'(1);
         cfg_rows = brs_pkg::SizeW'(1);
         cfg_orient = '0;
         cfg_top_down = 1'b0;
         phase = brs_pkg::PH_BLUE;
         held_blue = '0;
         held_green = '0;
         column = '0;
         row = '0;
         skip = '0;
         mismatch_count = 0;
      endfunction

      // Sizes of zero read as one; oversize values saturate at the maximum.
      function int clamp(logic [brs_pkg::SizeW-1:0] v, int maxv);
         if (v == 0)
            return 1;
         return (int'(v) > maxv) ? maxv : int'(v);
      endfunction

      function void write_register(brs_pkg::csr_index_type idx,
                                   logic [brs_pkg::SizeW-1:0] value);
         case (idx)
            brs_pkg::CSR_IMAGE_WIDTH:     cfg_width = value;
            brs_pkg::CSR_IMAGE_ROWS:      cfg_rows = value;
            brs_pkg::CSR_ORIENT_MODE:     cfg_orient = value[brs_pkg::OrientW-1:0];
            brs_pkg::CSR_SOURCE_TOP_DOWN: cfg_top_down = value[0];
            default:                      ;
         endcase
      endfunction

      // Advance the byte sequencer by one accepted request and queue the
      // words it produces.
      function void convert_byte(logic [7:0] b);
         int w;
         int h;
         int col;
         int src_row;
         int dest_row;
         int stride;
         int addr;
         bit flip;
         bit odd;
         bit row_end;
         bit image_end;
         rgb565_word_type r;
         w = clamp(cfg_width, MAX_WIDTH);
         h = clamp(cfg_rows, MAX_ROWS);
         case (phase)
            brs_pkg::PH_SKIP: begin
               if (skip <= 2'd1) begin
                  skip = '0;
                  phase = brs_pkg::PH_BLUE;
               end else begin
                  skip = skip - 2'd1;
               end
            end
            brs_pkg::PH_BLUE: begin
               held_blue = b;
               phase = brs_pkg::PH_GREEN;
            end
            brs_pkg::PH_GREEN: begin
               held_green = b;
               phase = brs_pkg::PH_RED;
            end
            default: begin
               // Counts beyond a shrunken size address the last column or row.
               flip = (cfg_orient == brs_pkg::ORIENT_TOP_DOWN && !cfg_top_down) ||
                      (cfg_orient == brs_pkg::ORIENT_BOTTOM_UP && cfg_top_down);
               col = (int'(column) < w) ? int'(column) : w - 1;
               src_row = (int'(row) < h) ? int'(row) : h - 1;
               dest_row = flip ? (h - 1 - src_row) : src_row;
               odd = w[0];
               stride = 2 * w + (odd ? 2 : 0);
               addr = HEADER_BYTES + stride * dest_row + 2 * col;
               row_end = (int'(column) + 1 >= w);
               image_end = row_end && (int'(row) + 1 >= h);

               r.word = {b[7:3], held_green[7:2], held_blue[7:3]};
               r.address = addr[brs_pkg::AddrW-1:0];
               r.is_pad = 1'b0;
               r.run_last = !(row_end && odd);
               r.image_done = image_end && !odd;
               pending_words.push_back(r);

               if (row_end) begin
                  column = '0;
                  row = image_end ? '0 : row + 1'b1;
                  skip = w[1:0];
                  phase = (skip != 2'd0) ? brs_pkg::PH_SKIP : brs_pkg::PH_BLUE;
               end else begin
                  column = column + 1'b1;
                  phase = brs_pkg::PH_BLUE;
               end

               // An odd row closes with a zero word that fills the stride.
               if (row_end && odd) begin
                  r.word = '0;
                  r.address = r.address + 2'd2;
                  r.is_pad = 1'b1;
                  r.run_last = 1'b1;
                  r.image_done = image_end;
                  pending_words.push_back(r);
               end
            end
         endcase
      endfunction

      // Print one line for the mismatch and count it.
      task report(string what, logic [brs_pkg::AddrW-1:0] want,
                  logic [brs_pkg::AddrW-1:0] got);
         mismatch_count++;
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
      endtask

      task check_word(rgb565_word_type got);
         rgb565_word_type want;
         if (pending_words.size() == 0) begin
            report("word with nothing outstanding, address", '0, got.address);
            return;
         end
         want = pending_words.pop_front();
         if (got.word !== want.word)
            report("output_word", brs_pkg::AddrW'(want.word), brs_pkg::AddrW'(got.word));
         if (got.address !== want.address)
            report("write_address", want.address, got.address);
         if (got.is_pad !== want.is_pad)
            report("is_pad", brs_pkg::AddrW'(want.is_pad), brs_pkg::AddrW'(got.is_pad));
         if (got.run_last !== want.run_last)
            report("run_last", brs_pkg::AddrW'(want.run_last),
                   brs_pkg::AddrW'(got.run_last));
         if (got.image_done !== want.image_done)
            report("image_done", brs_pkg::AddrW'(want.image_done),
                   brs_pkg::AddrW'(got.image_done));
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [7:0]                  req_source_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [brs_pkg::WordW-1:0]   rsp_output_word;
   logic [brs_pkg::AddrW-1:0]   rsp_write_address;
   logic                        rsp_is_pad;
   logic                        rsp_run_last;
   logic                        rsp_image_done;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [1:0]                  csr_index = '0;
   logic [brs_pkg::SizeW-1:0]   csr_data = '0;

   rgb565_scoreboard_type board = new();
   bit steady = 1'b0;
   int cycle_count = 0;

   bgr888_to_rgb565_row_stream dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_source_byte   (req_source_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_output_word   (rsp_output_word),
      .rsp_write_address (rsp_write_address),
      .rsp_is_pad        (rsp_is_pad),
      .rsp_run_last      (rsp_run_last),
      .rsp_image_done    (rsp_image_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Pause length: mostly none or short, now and then long.
   function int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Result side: check each accepted word, then decide the next stall.
   initial begin
      int stall_left;
      int len;
      rgb565_word_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.word = rsp_output_word;
            got.address = rsp_write_address;
            got.is_pad = rsp_is_pad;
            got.run_last = rsp_run_last;
            got.image_done = rsp_image_done;
            board.check_word(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            len = pick_gap();
            if (len > 0) begin
               stall_left = len - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Offer one byte, hold it until accepted, then maybe pause.
   task send_byte(input logic [7:0] b);
      int gap;
      req_valid <= 1'b1;
      req_source_byte <= b;
      do @(posedge clock); while (req_stall);
      board.convert_byte(b);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task send_random(input int count);
      for (int i = 0; i < count; i++)
         send_byte(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;
   endtask

   // Wait until every owed word has arrived and trailing bytes have settled.
   task wait_idle();
      while (board.pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the selected registers back to back, then release the port.
   task apply_settings(input logic [3:0] which, input logic [brs_pkg::SizeW-1:0] width,
                       input logic [brs_pkg::SizeW-1:0] rows,
                       input logic [brs_pkg::OrientW-1:0] orient,
                       input logic top_down);
      logic [brs_pkg::SizeW-1:0] values[4];
      brs_pkg::csr_index_type idx;
      values[0] = width;
      values[1] = rows;
      values[2] = brs_pkg::SizeW'(orient);
      values[3] = brs_pkg::SizeW'(top_down);
      for (int i = 0; i < 4; i++) begin
         if (which[i]) begin
            idx = brs_pkg::csr_index_type'(i);
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_data <= values[i];
            do @(posedge clock); while (!csr_ready);
            board.write_register(idx, values[i]);
         end
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] seq[$];
      logic [brs_pkg::SizeW-1:0] width;
      logic [brs_pkg::SizeW-1:0] rows;
      int sent;
      int count;
      int image_bytes;
      int w;
      int h;
      int pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default one-pixel image: odd width, one dropped byte, image ends on
      // the pad word. Black then white.
      seq = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      foreach (seq[i])
         send_byte(seq[i]);
      req_valid <= 1'b0;

      // Two-wide, two-row image flipped to top-down; the rows register then
      // shrinks mid-image so the second row ends the image early.
      wait_idle();
      apply_settings(4'b1111, brs_pkg::SizeW'(2), brs_pkg::SizeW'(2),
                     brs_pkg::ORIENT_TOP_DOWN, 1'b0);
      seq = '{8'h07, 8'hFC, 8'hF8, 8'hF8, 8'h03, 8'h07, 8'hAA, 8'h55};
      foreach (seq[i])
         send_byte(seq[i]);
      req_valid <= 1'b0;
      wait_idle();
      apply_settings(4'b0010, brs_pkg::SizeW'(2), brs_pkg::SizeW'(1),
                     brs_pkg::ORIENT_TOP_DOWN, 1'b0);
      seq = '{8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h01, 8'hFE};
      foreach (seq[i])
         send_byte(seq[i]);
      req_valid <= 1'b0;

      // A short run at the widest size with an oversize width value,
      // flipped: the first source row lands on the highest addresses.
      wait_idle();
      steady = 1'b1;
      apply_settings(4'b1111, 13'h1FFF, brs_pkg::SizeW'(MAX_ROWS),
                     brs_pkg::ORIENT_BOTTOM_UP, 1'b1);
      send_random(WIDE_RUN_BYTES);
      wait_idle();
      steady = 1'b0;

      // Random phases: new settings, then mostly whole images and sometimes
      // short fragments that leave the sequencer mid-pixel or mid-row.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            width = '0;
         else if (pick < 75)
            width = brs_pkg::SizeW'($urandom_range(1, 9));
         else if (pick < 92)
            width = brs_pkg::SizeW'($urandom_range(10, 40));
         else
            width = brs_pkg::SizeW'($urandom_range(4090, 8191));
         pick = $urandom_range(0, 99);
         if (pick < 8)
            rows = '0;
         else if (pick < 85)
            rows = brs_pkg::SizeW'($urandom_range(1, 4));
         else
            rows = brs_pkg::SizeW'($urandom_range(4090, 8191));
         apply_settings(4'($urandom_range(1, 15)), width, rows,
                        brs_pkg::OrientW'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)));
         steady = ($urandom_range(0, 3) == 0);

         w = board.clamp(board.cfg_width, MAX_WIDTH);
         h = board.clamp(board.cfg_rows, MAX_ROWS);
         image_bytes = h * (3 * w + w % 4);
         if ($urandom_range(0, 99) < 80 && image_bytes <= 200)
            count = image_bytes * $urandom_range(1, 2);
         else
            count = $urandom_range(1, 40);
         send_random(count);
         sent += count;
         wait_idle();
      end

      if (board.mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
src/brs_pkg.sv
src/brs_front.sv
src/brs_queue.sv
src/brs_back.sv
src/bgr888_to_rgb565_row_stream.sv
src/brs_checker.sv
verif/bgr888_to_rgb565_row_stream_tb.sv
